/* rtl/block_padding_checker_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the padding checker
// Immediate-consequence and next-cycle checks, clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef BLOCK_PADDING_CHECKER_MACROS_SVH
`define BLOCK_PADDING_CHECKER_MACROS_SVH

// cons must hold in the same cycle as ante
`define BPC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// cons must hold in the cycle after ante
`define BPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/bpc_pkg.sv */
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared widths, codes and types of the padding checker.
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam int LEN_W      = 16;  // internal length counter width
  localparam int OUT_LEN_W  = 16;
  localparam int DATA_W     = 8;
  localparam int STATUS_W   = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam int BSZ_W      = 9;   // block size with 0 read as 256

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAD_MODE   = 1'd1;

  localparam logic [1:0] MODE_ZERO   = 2'd0;
  localparam logic [1:0] MODE_MARKER = 2'd1;

  localparam logic [DATA_W-1:0] MARKER_BYTE = 8'h80;
  localparam logic [DATA_W-1:0] ZERO_BYTE   = 8'h00;
  localparam logic [7:0]        RUN_MAX     = 8'hFF;

  localparam logic [7:0] BLOCK_SIZE_RST = 8'd16;
  localparam logic [1:0] PAD_MODE_RST   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK             = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_LENGTH     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_MARKER_MISSING = 3'd2;
  localparam logic [STATUS_W-1:0] ST_MARKER_WRONG   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_COUNT_VALUE    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_COUNT_BYTES    = 3'd5;
  localparam logic [STATUS_W-1:0] ST_TOO_LONG       = 3'd6;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Snapshot of one finished message, taken by the front on its last byte
  typedef struct packed {
    logic [LEN_W-1:0]  byte_count;
    logic              overflow;
    logic              phase_ok;
    logic              seen_nonzero;
    logic [LEN_W-1:0]  nonzero_index;
    logic [DATA_W-1:0] nonzero_value;
    logic [DATA_W-1:0] run_value;
    logic [7:0]        run_length;
    logic [BSZ_W-1:0]  bsz;
    logic [1:0]        pad_mode;
  } bpc_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } bpc_qstat_t;

endpackage

/* rtl/bpc_if.sv */
// ----------------------------------------------------------------------------
// bpc channel interfaces
// Valid/ready channels for message bytes and per-message results.
// ----------------------------------------------------------------------------
interface bpc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface bpc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] stripped_length;
  logic [2:0]  status;

  modport source (output valid, output stripped_length, output status, input ready);
  modport sink   (input valid, input stripped_length, input status, output ready);
endinterface

/* rtl/bpc_queue.sv */
// ----------------------------------------------------------------------------
// bpc_queue
// Short FIFO of message snapshots between front and back.
// ----------------------------------------------------------------------------
module bpc_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  bpc_pkg::bpc_rec_t  push_rec,
  input  logic               pop,
  output bpc_pkg::bpc_rec_t  head_rec,
  output bpc_pkg::bpc_qstat_t stat
);
  import bpc_pkg::*;

  bpc_rec_t            mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]   count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  assign head_rec   = mem_r[rd_ptr_r];
  assign stat.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);

endmodule

/* rtl/bpc_front.sv */
// ----------------------------------------------------------------------------
// bpc_front
// Per-byte stream tracking and config registers; snapshots on the last byte.
// ----------------------------------------------------------------------------
module bpc_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bpc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                              accept,
  input  logic [bpc_pkg::DATA_W-1:0]        data_byte,
  input  logic                              last_byte,
  output logic                              push,
  output bpc_pkg::bpc_rec_t                 push_rec
);
  import bpc_pkg::*;

  logic [7:0]        block_size_r;
  logic [1:0]        pad_mode_r;

  logic [LEN_W-1:0]  byte_count_r, byte_count_nxt;
  logic [7:0]        phase_r, phase_nxt, phase_inc;
  logic [LEN_W-1:0]  nz_index_r, nz_index_nxt;
  logic [DATA_W-1:0] nz_value_r, nz_value_nxt;
  logic              seen_nz_r, seen_nz_nxt;
  logic [DATA_W-1:0] run_value_r, run_value_nxt;
  logic [7:0]        run_length_r, run_length_nxt;
  logic              overflow_r, overflow_nxt;
  logic              at_max;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_size_r <= BLOCK_SIZE_RST;
      pad_mode_r   <= PAD_MODE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BLOCK_SIZE: block_size_r <= cfg_wdata[7:0];
        CFG_PAD_MODE:   pad_mode_r   <= cfg_wdata[1:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    at_max         = (byte_count_r == {LEN_W{1'b1}});
    byte_count_nxt = at_max ? byte_count_r : byte_count_r + 1'b1;
    overflow_nxt   = overflow_r | at_max;

    // block size 0 means 256: the 8-bit phase just wraps
    phase_inc = phase_r + 8'd1;
    phase_nxt = (block_size_r != 8'd0 && phase_inc >= block_size_r) ? 8'd0 : phase_inc;

    seen_nz_nxt  = seen_nz_r;
    nz_value_nxt = nz_value_r;
    nz_index_nxt = nz_index_r;
    if (data_byte != ZERO_BYTE) begin
      seen_nz_nxt  = 1'b1;
      nz_value_nxt = data_byte;
      nz_index_nxt = byte_count_r;
    end

    if (run_length_r != 8'd0 && data_byte == run_value_r) begin
      run_value_nxt  = run_value_r;
      run_length_nxt = (run_length_r == RUN_MAX) ? run_length_r : run_length_r + 8'd1;
    end else begin
      run_value_nxt  = data_byte;
      run_length_nxt = 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      phase_r      <= '0;
      nz_index_r   <= '0;
      nz_value_r   <= '0;
      seen_nz_r    <= 1'b0;
      run_value_r  <= '0;
      run_length_r <= '0;
      overflow_r   <= 1'b0;
    end else if (accept) begin
      if (last_byte) begin
        byte_count_r <= '0;
        phase_r      <= '0;
        nz_index_r   <= '0;
        nz_value_r   <= '0;
        seen_nz_r    <= 1'b0;
        run_value_r  <= '0;
        run_length_r <= '0;
        overflow_r   <= 1'b0;
      end else begin
        byte_count_r <= byte_count_nxt;
        phase_r      <= phase_nxt;
        nz_index_r   <= nz_index_nxt;
        nz_value_r   <= nz_value_nxt;
        seen_nz_r    <= seen_nz_nxt;
        run_value_r  <= run_value_nxt;
        run_length_r <= run_length_nxt;
        overflow_r   <= overflow_nxt;
      end
    end
  end

  assign push = accept & last_byte;

  always_comb begin
    push_rec.byte_count    = byte_count_nxt;
    push_rec.overflow      = overflow_nxt;
    push_rec.phase_ok      = (phase_nxt == 8'd0);
    push_rec.seen_nonzero  = seen_nz_nxt;
    push_rec.nonzero_index = nz_index_nxt;
    push_rec.nonzero_value = nz_value_nxt;
    push_rec.run_value     = run_value_nxt;
    push_rec.run_length    = run_length_nxt;
    push_rec.bsz           = (block_size_r == 8'd0) ? BSZ_W'(256) : {1'b0, block_size_r};
    push_rec.pad_mode      = pad_mode_r;
  end

endmodule

/* rtl/bpc_back.sv */
// ----------------------------------------------------------------------------
// bpc_back
// Grades one message snapshot into length and status; output register.
// ----------------------------------------------------------------------------
module bpc_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  bpc_pkg::bpc_qstat_t                qstat,
  input  bpc_pkg::bpc_rec_t                  head_rec,
  output logic                               pop,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic [bpc_pkg::OUT_LEN_W-1:0]      out_length,
  output logic [bpc_pkg::STATUS_W-1:0]       out_status
);
  import bpc_pkg::*;

  localparam int WIDE_W = 33;

  logic                  valid_r;
  logic [OUT_LEN_W-1:0]  length_r;
  logic [STATUS_W-1:0]   status_r;

  logic [STATUS_W-1:0]   st;
  logic [LEN_W:0]        len;
  logic [WIDE_W-1:0]     len_wide;
  logic [BSZ_W-1:0]      val9;

  always_comb begin
    st   = ST_OK;
    len  = '0;
    val9 = {1'b0, head_rec.run_value};
    if (head_rec.overflow) begin
      st = ST_TOO_LONG;
    end else if (!head_rec.phase_ok) begin
      st = ST_BAD_LENGTH;
    end else begin
      case (head_rec.pad_mode)
        MODE_ZERO: begin
          len = head_rec.seen_nonzero ? {1'b0, head_rec.nonzero_index} + 1'b1 : '0;
        end
        MODE_MARKER: begin
          if (!head_rec.seen_nonzero) begin
            st = ST_MARKER_MISSING;
          end else if (head_rec.nonzero_value != MARKER_BYTE) begin
            st = ST_MARKER_WRONG;
          end else begin
            len = {1'b0, head_rec.nonzero_index};
          end
        end
        default: begin
          // count mode, also pad mode 3
          if (head_rec.run_value == 8'd0 || val9 > head_rec.bsz) begin
            st = ST_COUNT_VALUE;
          end else if (head_rec.run_length < head_rec.run_value) begin
            st = ST_COUNT_BYTES;
          end else begin
            len = {1'b0, head_rec.byte_count} - (LEN_W + 1)'(head_rec.run_value);
          end
        end
      endcase
    end
    len_wide = {{(WIDE_W - LEN_W - 1){1'b0}}, len};
    if (st == ST_OK && len_wide > WIDE_W'(65535)) begin
      st = ST_TOO_LONG;
    end
    if (st != ST_OK) begin
      len_wide = '0;
    end
  end

  // take a snapshot whenever the output register is free or being drained
  assign pop = !qstat.empty && (!valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      length_r <= len_wide[OUT_LEN_W-1:0];
      status_r <= st;
    end
  end

  assign out_valid  = valid_r;
  assign out_length = length_r;
  assign out_status = status_r;

endmodule

/* rtl/block_padding_checker.sv */
// ----------------------------------------------------------------------------
// block_padding_checker
// Padding removal check on a byte stream: zero, 0x80 marker or count padding.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one message byte per transfer, last_byte marks the final byte.
//   out_ch : one result per message: stripped_length and status (0 = ok,
//            length forced to 0 on any error).
//   cfg_*  : write block_size (index 0) and pad_mode (index 1) while idle.
// Throughput: one byte per cycle, back to back across messages, unless the queue is full.
// Result path: with the queue and output register empty, the last byte's
//   snapshot is written into the snapshot queue, then into the output
//   register, which raises out_ch.valid.
// The front tracks counts per byte; only final bytes enter the two-entry
// snapshot queue, so in_ch.ready drops only once that queue is full.
// Stall: when out_ch.ready is low the result holds in the output register;
//   up to two further messages can finish into the queue before in_ch stalls.
// Reset: rst_n low (synchronous) clears all stream state and the queue, and
//   sets block_size to 16 and pad_mode to count mode.
// ----------------------------------------------------------------------------
`include "block_padding_checker_macros.svh"

module block_padding_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bpc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  bpc_in_if.sink                           in_ch,
  bpc_out_if.source                        out_ch
);
  import bpc_pkg::*;

  logic       in_accept;
  logic       push;
  logic       pop;
  bpc_rec_t   push_rec;
  bpc_rec_t   head_rec;
  bpc_qstat_t qstat;

  // front stalls only when no room is left for another finished message
  assign in_ch.ready = !qstat.full;
  assign in_accept   = in_ch.valid & in_ch.ready;

  bpc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .accept    (in_accept),
    .data_byte (in_ch.data_byte),
    .last_byte (in_ch.last_byte),
    .push      (push),
    .push_rec  (push_rec)
  );

  bpc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head_rec (head_rec),
    .stat     (qstat)
  );

  bpc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .qstat      (qstat),
    .head_rec   (head_rec),
    .pop        (pop),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .out_length (out_ch.stripped_length),
    .out_status (out_ch.status)
  );

  // Any error reports a zero length
  `BPC_ASSERT_SAME(a_err_len_zero, out_ch.valid && out_ch.status != ST_OK, out_ch.stripped_length == '0, "error result with nonzero length")

  // Status stays within the defined codes
  `BPC_ASSERT_SAME(a_status_range, out_ch.valid, out_ch.status <= ST_TOO_LONG, "undefined status code")

  // Last byte into an empty pipe shows a result once it has passed the queue and the output register
  `BPC_ASSERT_NEXT(a_result_latency, in_accept && in_ch.last_byte && qstat.empty && !out_ch.valid, ##1 out_ch.valid, "result missing two cycles after last byte")

  // A queued message is always drained when the output is free
  `BPC_ASSERT_SAME(a_drain, !qstat.empty && !out_ch.valid, pop, "queue not drained into idle output")

endmodule

/* tb/unpad_tb_pkg.sv */
// ----------------------------------------------------------------------------
// unpad_tb_pkg
// Expected-result bookkeeping for the padding checker testbench: a byte-level
// copy of the checker state and a queue of the results it should produce.
// ----------------------------------------------------------------------------
package unpad_tb_pkg;

  import bpc_pkg::*;

  // count padding has no name in the RTL package; mode 3 decodes the same way
  localparam logic [1:0] MODE_COUNT     = 2'd2;
  localparam logic [1:0] MODE_COUNT_ALT = 2'd3;

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [OUT_LEN_W-1:0] stripped_length;
    logic [STATUS_W-1:0]  status;
  } unpad_result_t;

  class unpad_scoreboard;

    logic [7:0]  block_size;
    logic [1:0]  pad_mode;

    logic [15:0] byte_count;
    logic [7:0]  block_phase;
    logic [15:0] nonzero_index;
    logic [7:0]  nonzero_value;
    bit          seen_nonzero;
    logic [7:0]  run_value;
    logic [7:0]  run_length;
    bit          length_overflow;

    unpad_result_t expected_q[$];
    int            error_count;
    int            mismatch_count;

    function new();
      block_size     = BLOCK_SIZE_RST;
      pad_mode       = PAD_MODE_RST;
      error_count    = 0;
      mismatch_count = 0;
      clear_stream();
    endfunction

    function void clear_stream();
      byte_count      = '0;
      block_phase     = '0;
      nonzero_index   = '0;
      nonzero_value   = '0;
      seen_nonzero    = 1'b0;
      run_value       = '0;
      run_length      = '0;
      length_overflow = 1'b0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_BLOCK_SIZE) begin
        block_size = data;
      end else if (idx == CFG_PAD_MODE) begin
        pad_mode = data[1:0];
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // one accepted input byte; a final byte queues the expected result
    function void take_byte(logic [7:0] b, logic last);
      logic [8:0]    bsz;
      logic [15:0]   pos;
      logic [16:0]   len;
      logic [2:0]    st;
      unpad_result_t res;
      bsz = (block_size == 8'd0) ? 9'd256 : {1'b0, block_size};
      pos = byte_count;

      if (byte_count == 16'hFFFF) begin
        length_overflow = 1'b1;
      end else begin
        byte_count = byte_count + 16'd1;
      end

      block_phase = block_phase + 8'd1;
      if ({1'b0, block_phase} >= bsz) begin
        block_phase = 8'd0;
      end

      if (b != ZERO_BYTE) begin
        seen_nonzero  = 1'b1;
        nonzero_value = b;
        nonzero_index = pos;
      end

      if (run_length != 8'd0 && b == run_value) begin
        if (run_length != RUN_MAX) begin
          run_length = run_length + 8'd1;
        end
      end else begin
        run_value  = b;
        run_length = 8'd1;
      end

      if (!last) begin
        return;
      end

      len = '0;
      st  = ST_OK;
      if (length_overflow) begin
        st = ST_TOO_LONG;
      end else if (block_phase != 8'd0) begin
        st = ST_BAD_LENGTH;
      end else if (pad_mode == MODE_ZERO) begin
        len = seen_nonzero ? {1'b0, nonzero_index} + 17'd1 : 17'd0;
      end else if (pad_mode == MODE_MARKER) begin
        if (!seen_nonzero) begin
          st = ST_MARKER_MISSING;
        end else if (nonzero_value != MARKER_BYTE) begin
          st = ST_MARKER_WRONG;
        end else begin
          len = {1'b0, nonzero_index};
        end
      end else begin
        if (run_value == 8'd0 || {1'b0, run_value} > bsz) begin
          st = ST_COUNT_VALUE;
        end else if (run_length < run_value) begin
          st = ST_COUNT_BYTES;
        end else begin
          len = {1'b0, byte_count} - {9'd0, run_value};
        end
      end

      if (st == ST_OK && len > 17'h0FFFF) begin
        st = ST_TOO_LONG;
      end
      if (st != ST_OK) begin
        len = '0;
      end

      res.stripped_length = len[15:0];
      res.status          = st;
      expected_q.push_back(res);
      clear_stream();
    endfunction

    function void check_result(logic [OUT_LEN_W-1:0] got_len, logic [STATUS_W-1:0] got_st);
      unpad_result_t exp_res;
      if (expected_q.size() == 0) begin
        error_count++;
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
          $display("unexpected result: len=%0d status=%0d", got_len, got_st);
        end
        return;
      end
      exp_res = expected_q.pop_front();
      if (got_len !== exp_res.stripped_length || got_st !== exp_res.status) begin
        error_count++;
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
          $display("mismatch: expected len=%0d status=%0d, got len=%0d status=%0d",
                   exp_res.stripped_length, exp_res.status, got_len, got_st);
        end
      end
    endfunction

    function void check_drained();
      if (expected_q.size() != 0) begin
        error_count++;
        $display("%0d expected results never arrived", expected_q.size());
      end
    endfunction

  endclass

endpackage

/* tb/block_padding_checker_test.sv */
// ----------------------------------------------------------------------------
// block_padding_checker_test
// Self-checking bench for the padding checker: directed messages for every
// mode and every error status except too long, then random well-formed and
// broken messages under random idling on both channels, each result compared
// against a byte-level predictor.
// ----------------------------------------------------------------------------
module block_padding_checker_test;

  timeunit 1ns;
  timeprecision 1ps;

  import bpc_pkg::*;
  import unpad_tb_pkg::*;

  localparam int STALL_LIMIT  = 4000;   // cycles with no transfer at all
  localparam int RANDOM_BYTES = 800;    // random bytes after the directed part
  localparam int PHASE_BYTES  = 100;
  localparam int HOLD_CYCLES  = 300;    // long receiver back-pressure stretch

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  bpc_in_if  in_ch ();
  bpc_out_if out_ch ();

  block_padding_checker uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  unpad_scoreboard unpad_sb = new();

  // idle-cycle ceilings per side; 0 gives back-to-back stretches
  int in_gap_max    = 13;
  int out_stall_max = 13;
  // one-shot request for a long receiver hold-off, taken by the receiver
  int hold_off_len  = 0;

  logic [7:0] msg_bytes[$];
  int         stim_bytes;
  int         idle_cycles = 0;

  // --------------------------------------------------------------------------
  // Watchdog: any cycle without a transfer on either channel counts toward
  // the limit. A hung block or a lost result ends the run here.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL block_padding_checker");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Result side: random stall before each transfer, or the long hold-off when
  // one was requested. Every accepted result goes straight to the scoreboard.
  // --------------------------------------------------------------------------
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = $urandom_range(0, out_stall_max);
      if (hold_off_len > 0) begin
        stall        = hold_off_len;
        hold_off_len = 0;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      unpad_sb.check_result(out_ch.stripped_length, out_ch.status);
    end
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------

  // One byte transfer, preceded by a random gap. valid stays up across
  // back-to-back bytes; the predictor sees the byte once it is accepted.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last_byte <= last;
    do @(posedge clk); while (!in_ch.ready);
    unpad_sb.take_byte(b, last);
  endtask

  task automatic send_message();
    for (int i = 0; i < msg_bytes.size(); i++) begin
      send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
    end
    stim_bytes += msg_bytes.size();
  endtask

  // Drain before a register write: drop valid, wait for every expected
  // result, then let the result path empty fully.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (unpad_sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Both registers, back to back. Upper bits of the pad_mode word are junk
  // that the block must ignore.
  task automatic set_config(input logic [7:0] bs, input logic [1:0] mode);
    logic [CFG_DATA_W-1:0] mode_word;
    mode_word = {6'($urandom_range(0, 63)), mode};
    cfg_we    <= 1'b1;
    cfg_index <= CFG_BLOCK_SIZE;
    cfg_wdata <= bs;
    @(posedge clk);
    cfg_index <= CFG_PAD_MODE;
    cfg_wdata <= mode_word;
    @(posedge clk);
    cfg_we    <= 1'b0;
    unpad_sb.write_reg(CFG_BLOCK_SIZE, bs);
    unpad_sb.write_reg(CFG_PAD_MODE, mode_word);
  endtask

  // Random message for the current setting. Most are whole blocks with a
  // valid pad tail; some have a bad length, a corrupted tail or pure noise.
  task automatic build_message(input int bsz, input logic [1:0] mode);
    int len, pad, kind, pos, max_pad, tail_span;
    msg_bytes.delete();
    kind = $urandom_range(0, 9);
    len  = bsz * $urandom_range(1, (bsz > 16) ? 1 : 3);
    if (kind == 0) begin
      len = $urandom_range(1, len + bsz);
    end
    for (int i = 0; i < len; i++) begin
      msg_bytes.push_back(($urandom_range(0, 3) == 0) ? ZERO_BYTE : 8'($urandom_range(0, 255)));
    end
    max_pad = (len < bsz) ? len : bsz;
    if (max_pad > 255) begin
      max_pad = 255;
    end

    if (kind <= 8) begin
      case (mode)
        MODE_ZERO: begin
          pad = $urandom_range(0, len - 1);
          for (int i = len - pad; i < len; i++) msg_bytes[i] = ZERO_BYTE;
        end
        MODE_MARKER: begin
          pad = $urandom_range(1, max_pad);
          msg_bytes[len - pad] = MARKER_BYTE;
          for (int i = len - pad + 1; i < len; i++) msg_bytes[i] = ZERO_BYTE;
        end
        default: begin
          pad = $urandom_range(1, max_pad);
          for (int i = len - pad; i < len; i++) msg_bytes[i] = 8'(pad);
        end
      endcase
    end

    // flip one byte near the end to break the pad
    if (kind == 7 || kind == 8) begin
      tail_span = (len < 4) ? len : 4;
      pos = len - 1 - $urandom_range(0, tail_span - 1);
      msg_bytes[pos] = msg_bytes[pos] ^ 8'($urandom_range(1, 255));
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int         sel, bsz, phase_bytes;
    logic [7:0] bs;
    logic [1:0] mode;

    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= CFG_BLOCK_SIZE;
    cfg_wdata       <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.data_byte <= '0;
    in_ch.last_byte <= 1'b0;
    stim_bytes       = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Reset setting (block 16, count mode): 14 data bytes and two pad bytes
    msg_bytes = {8'hFF, 8'h00, 8'h5A, 8'hA5, 8'h01, 8'h80, 8'h7F, 8'hFE,
                 8'h00, 8'h33, 8'hCC, 8'h0F, 8'hF0, 8'h02, 8'h02, 8'h02};
    send_message();

    // Zero padding, block 1: all zero gives length 0
    settle();
    set_config(8'd1, MODE_ZERO);
    msg_bytes = {8'h00};
    send_message();
    msg_bytes = {8'hFF};
    send_message();

    // Marker padding, block 2: good marker, all zero (missing), wrong last
    // nonzero byte, then an odd length
    settle();
    set_config(8'd2, MODE_MARKER);
    msg_bytes = {8'h80, 8'h00};
    send_message();
    msg_bytes = {8'h00, 8'h00};
    send_message();
    msg_bytes = {8'h41, 8'h01};
    send_message();
    msg_bytes = {8'h12, 8'h80, 8'h00};
    send_message();

    // Count padding through mode 3, block 4: good pad, pad value zero, pad
    // value above the block size, run shorter than the pad value
    settle();
    set_config(8'd4, MODE_COUNT_ALT);
    msg_bytes = {8'h7F, 8'h02, 8'h02, 8'h02};
    send_message();
    msg_bytes = {8'h01, 8'h02, 8'h03, 8'h00};
    send_message();
    msg_bytes = {8'h01, 8'h02, 8'h03, 8'h05};
    send_message();
    msg_bytes = {8'h01, 8'h03, 8'h02, 8'h03};
    send_message();

    // Block size 0 reads as 256; a 256-byte run of 0xFF also saturates the
    // run counter
    settle();
    set_config(8'd0, MODE_COUNT);
    msg_bytes.delete();
    repeat (256) msg_bytes.push_back(8'hFF);
    send_message();

    // Back-pressure: one-byte messages sent without gaps while the receiver
    // holds off, so the result queue fills and in_ch.ready drops
    settle();
    set_config(8'd1, MODE_ZERO);
    in_gap_max   = 0;
    hold_off_len = HOLD_CYCLES;
    for (int i = 0; i < 10; i++) begin
      msg_bytes = {8'($urandom_range(0, 255))};
      send_message();
    end

    // Random phases: a new setting each time, mixed idling per side
    stim_bytes = 0;
    while (stim_bytes < RANDOM_BYTES) begin
      sel = $urandom_range(0, 9);
      if (sel <= 5) begin
        bs = 8'($urandom_range(1, 8));
      end else if (sel == 6) begin
        bs = 8'd16;
      end else if (sel == 7) begin
        bs = 8'($urandom_range(17, 255));
      end else if (sel == 8) begin
        bs = 8'd255;
      end else begin
        bs = 8'd0;
      end
      mode = 2'($urandom_range(0, 3));
      bsz  = (bs == 8'd0) ? 256 : int'(bs);

      settle();
      set_config(bs, mode);
      in_gap_max    = ($urandom_range(0, 2) == 0) ? 0 : 13;
      out_stall_max = ($urandom_range(0, 2) == 0) ? 0 : 13;

      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) begin
        build_message(bsz, mode);
        phase_bytes += msg_bytes.size();
        send_message();
      end
    end

    // Drain, then allow for the two-stage result path before the verdict
    in_ch.valid <= 1'b0;
    while (unpad_sb.pending() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    unpad_sb.check_drained();
    if (unpad_sb.error_count == 0) begin
      $display("PASS block_padding_checker");
    end else begin
      $display("FAIL block_padding_checker");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/bpc_pkg.sv
rtl/bpc_if.sv
rtl/bpc_queue.sv
rtl/bpc_front.sv
rtl/bpc_back.sv
rtl/block_padding_checker.sv
tb/unpad_tb_pkg.sv
tb/block_padding_checker_test.sv
